FILE: design/bole_pkg.sv
package bole_pkg;

	// List geometry.
	localparam int CAPACITY = 16;
	localparam int KEY_W    = 31;
	localparam int FUNC_W   = 3;
	localparam int POS_W    = 4;
	localparam int LEN_W    = 5;
	localparam int STAT_W   = 2;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int WIDE_W   = CNT_W + POS_W;

	// Operation codes.
	localparam logic [FUNC_W-1:0] OP_ADD_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] OP_DEL_FRONT = 3'd1;
	localparam logic [FUNC_W-1:0] OP_DEL_BACK  = 3'd2;
	localparam logic [FUNC_W-1:0] OP_DEL_AT    = 3'd3;
	localparam logic [FUNC_W-1:0] OP_SEARCH    = 3'd4;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

	// Command broadcast from the controller to every cell.
	typedef struct packed {
		logic             add_en;
		logic             del_en;
		logic [IDX_W-1:0] del_idx;
		logic             search_en;
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] count;
	} cell_ctrl_t;

endpackage

FILE: design/bounded_ordered_list_engine.sv
// A transfer on the input gives its result in the output register in the cycle after it.
// Throughput: one item per cycle while the output register is drained; every cell shifts or compares in the same cycle.
// The input is ready whenever the output register is empty or being drained.
// Reset (arst_n low) empties the list and the output register; cell contents are not cleared.
module bounded_ordered_list_engine import bole_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [FUNC_W-1:0] func,
	input  logic [KEY_W-1:0]  reg_key,
	input  logic [POS_W-1:0]  position,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              found,
	output logic [KEY_W-1:0]  removed_key,
	output logic [LEN_W-1:0]  list_length,
	output logic [STAT_W-1:0] status
);

	logic                    in_fire;
	logic [CNT_W-1:0]        count_q;
	logic                    out_valid_q;
	logic                    found_q;
	logic [KEY_W-1:0]        removed_key_q;
	logic [LEN_W-1:0]        list_length_q;
	logic [STAT_W-1:0]       status_q;
	cell_ctrl_t              ctrl;
	logic [STAT_W-1:0]       status_d;
	logic [CNT_W-1:0]        count_d;
	logic [WIDE_W-1:0]       pos_wide;
	logic [WIDE_W-1:0]       cnt_wide;
	logic [KEY_W-1:0]        cell_key [CAPACITY];
	logic [CAPACITY-1:0]     cell_match;
	logic [KEY_W-1:0]        cell_take [CAPACITY];
	logic [KEY_W-1:0]        take_or;
	logic [CNT_W+LEN_W-1:0]  len_wide;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign pos_wide = WIDE_W'(position);
	assign cnt_wide = WIDE_W'(count_q);

	// Decode the operation into a cell command, a status and the next length.
	always_comb begin
		ctrl           = '0;
		ctrl.key       = reg_key;
		ctrl.count     = count_q;
		status_d       = ST_OK;
		count_d        = count_q;
		case (func)
			OP_ADD_FRONT: begin
				if (count_q >= CNT_W'(CAPACITY)) begin
					status_d = ST_FULL;
				end else begin
					ctrl.add_en = in_fire;
					count_d     = count_q + CNT_W'(1);
				end
			end
			OP_DEL_FRONT: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					ctrl.del_en  = in_fire;
					ctrl.del_idx = '0;
					count_d      = count_q - CNT_W'(1);
				end
			end
			OP_DEL_BACK: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					ctrl.del_en  = in_fire;
					ctrl.del_idx = IDX_W'(count_q - CNT_W'(1));
					count_d      = count_q - CNT_W'(1);
				end
			end
			OP_DEL_AT: begin
				if (pos_wide >= cnt_wide) begin
					status_d = ST_RANGE;
				end else begin
					ctrl.del_en  = in_fire;
					ctrl.del_idx = IDX_W'(pos_wide);
					count_d      = count_q - CNT_W'(1);
				end
			end
			OP_SEARCH: begin
				ctrl.search_en = 1'b1;
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// Row of entry cells; each takes its neighbor's number on a shift.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KEY_W-1:0] left_key;
		logic [KEY_W-1:0] right_key;

		if (i == 0) begin : g_first
			assign left_key = reg_key;
		end else begin : g_mid_l
			assign left_key = cell_key[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_key = cell_key[i];
		end else begin : g_mid_r
			assign right_key = cell_key[i+1];
		end

		bole_cell u_cell (
			.clk       (clk),
			.idx       (IDX_W'(i)),
			.ctrl      (ctrl),
			.left_key  (left_key),
			.right_key (right_key),
			.key       (cell_key[i]),
			.match     (cell_match[i]),
			.take_key  (cell_take[i])
		);
	end

	// At most one cell drives the removed number, so an OR collects it.
	always_comb begin
		take_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			take_or = take_or | cell_take[i];
		end
	end

	assign len_wide = {{LEN_W{1'b0}}, count_d};

	// List length and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			found_q       <= |cell_match;
			removed_key_q <= take_or;
			list_length_q <= len_wide[LEN_W-1:0];
			status_q      <= status_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign removed_key = removed_key_q;
	assign list_length = list_length_q;
	assign status      = status_q;

	// The length never exceeds the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("list length above capacity");

	// An accepted add to a non-full list puts the number at the front.
	a_add_front: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && func == OP_ADD_FRONT && count_q < CNT_W'(CAPACITY)) |=>
		(cell_key[0] == $past(reg_key) && count_q == $past(count_q) + CNT_W'(1)))
		else $error("add did not reach the front cell");

	// A refused operation reports no found flag and no removed number.
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK) |-> (!found_q && removed_key_q == '0))
		else $error("error result carries data");

	// Only a search can set the found flag, and a search never changes the length.
	a_search_len: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && func == OP_SEARCH) |=> (count_q == $past(count_q)))
		else $error("search changed the list length");

endmodule

FILE: design/bole_cell.sv
module bole_cell import bole_pkg::*; (
	input  logic             clk,
	input  logic [IDX_W-1:0] idx,
	input  cell_ctrl_t       ctrl,
	input  logic [KEY_W-1:0] left_key,
	input  logic [KEY_W-1:0] right_key,
	output logic [KEY_W-1:0] key,
	output logic             match,
	output logic [KEY_W-1:0] take_key
);

	logic [KEY_W-1:0] key_q;
	logic             occupied;

	// Add shifts every entry one place back; a remove closes the gap at del_idx.
	always_ff @(posedge clk) begin
		if (ctrl.add_en) begin
			key_q <= left_key;
		end else if (ctrl.del_en && (idx >= ctrl.del_idx)) begin
			key_q <= right_key;
		end
	end

	// Only entries below the current length take part in a search.
	assign occupied = CNT_W'(idx) < ctrl.count;
	assign match    = ctrl.search_en && occupied && (key_q == ctrl.key);

	// The cell being removed puts its number on the OR bus.
	assign take_key = (ctrl.del_en && (idx == ctrl.del_idx)) ? key_q : '0;
	assign key      = key_q;

endmodule
